/* hdl/slot_table_with_hole_reuse_unit_defines.svh */
// Assertion macros shared by the slot table RTL.
// Included by every module that carries concurrent checks.
`ifndef SLOT_TABLE_WITH_HOLE_REUSE_UNIT_DEFINES_SVH
`define SLOT_TABLE_WITH_HOLE_REUSE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define STHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot table check failed");
// next-cycle implication, disabled in reset
`define STHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot table check failed");
`else
`define STHR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STHR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/sthr_pkg.sv */
// Shared types for the slot table: opcodes and controller/datapath links.
// No dependencies.
`default_nettype none
package sthr_pkg;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_GET      = 3'd2,
    OP_SET      = 3'd3,
    OP_GET_LAST = 3'd4,
    OP_DELETE   = 3'd5
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input beat, launch the table read
    logic commit;  // update state, write the table, load the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register empty or draining this cycle
  } dp_status_t;

endpackage
`default_nettype wire

/* hdl/slot_table_with_hole_reuse_unit.sv */
// Slot table with hole reuse: top level joining controller and datapath.
// Depends on sthr_pkg, sthr_ctrl and sthr_dp.
`default_nettype none
// Table of CAPACITY words with a fill count and one remembered hole. Each
// input beat is one operation (push, pop, get, set, get last, delete) and
// yields exactly one result beat carrying the word read, the push slot, the
// fill count after the operation and a flag for a push refused on a full table.
// An operation is accepted in ST_IDLE, which launches the single table read;
// ST_EXEC then writes the table and loads the result register once the result
// slot is free. There is no forwarding from that write to a following read, so
// the sequencer never overlaps operations: a new beat is not accepted until the
// last one commits. A result that is not taken stalls the commit, and no next
// beat is accepted while it waits. Slot contents are undefined until written;
// there is no clearing pass.
module slot_table_with_hole_reuse_unit #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  slot_index_i,
  input  logic [31:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_out_o,
  output logic [7:0]  pushed_index_o,
  output logic [8:0]  fill_count_o,
  output logic        push_refused_o
);
  import sthr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sthr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sthr_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .slot_index_i   (slot_index_i),
    .value_in_i     (value_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_out_o    (value_out_o),
    .pushed_index_o (pushed_index_o),
    .fill_count_o   (fill_count_o),
    .push_refused_o (push_refused_o)
  );

endmodule
`default_nettype wire

/* hdl/sthr_ctrl.sv */
// Sequencer for the slot table: accept, then commit once the result slot frees.
// Depends on sthr_pkg.
`default_nettype none
module sthr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sthr_pkg::dp_status_t status_i,
  output sthr_pkg::dp_cmd_t    cmd_o
);
  import sthr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/sthr_dp.sv */
// Datapath for the slot table: slot memory, count, hole, result register.
// Depends on sthr_pkg and the assertion macro header.
`default_nettype none
`include "slot_table_with_hole_reuse_unit_defines.svh"
module sthr_dp #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sthr_pkg::dp_cmd_t    cmd_i,
  output sthr_pkg::dp_status_t status_o,
  input  logic [2:0]           opcode_i,
  input  logic [7:0]           slot_index_i,
  input  logic [31:0]          value_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          value_out_o,
  output logic [7:0]           pushed_index_o,
  output logic [8:0]           fill_count_o,
  output logic                 push_refused_o
);
  import sthr_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rdata_q;

  logic [2:0]           op_q;
  logic [7:0]           idx_q;
  logic [WORD_BITS-1:0] val_q;
  logic [CW-1:0]        count_q, count_d;
  logic [7:0]           hole_q, hole_d;

  logic                 out_valid_q;
  logic [31:0]          value_out_q, value_out_d;
  logic [7:0]           pidx_q, pidx_d;
  logic [8:0]           fill_q;
  logic                 refused_q, refused_d;

  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rval;
  logic [63:0]          rval_wide;
  logic                 in_range, hole_ok, nonempty, full;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  // read address from the incoming beat: last entry or addressed slot
  always_comb begin
    if (opcode_i == OP_POP || opcode_i == OP_GET_LAST) begin
      rd_addr = AW'(count_q - CW'(1));
    end else begin
      rd_addr = AW'(slot_index_i);
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rdata_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // captured beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      idx_q <= slot_index_i;
      val_q <= WORD_BITS'(value_in_i);
    end
  end

  assign in_range = CMPW'(idx_q) < CMPW'(count_q);
  assign hole_ok  = (hole_q != 8'd0) && (CMPW'(hole_q) < CMPW'(count_q));
  assign nonempty = count_q != '0;
  assign full     = count_q >= CW'(CAPACITY);

  // operation decode at commit
  always_comb begin
    count_d   = count_q;
    hole_d    = hole_q;
    rval      = '0;
    pidx_d    = 8'd0;
    refused_d = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = AW'(idx_q);
    wr_data   = '0;
    unique case (op_q)
      OP_PUSH: begin
        if (hole_ok) begin
          wr_en   = 1'b1;
          wr_addr = AW'(hole_q);
          wr_data = val_q;
          pidx_d  = hole_q;
          hole_d  = 8'd0;
        end else if (full) begin
          refused_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(count_q);
          wr_data = val_q;
          pidx_d  = 8'(count_q);
          count_d = count_q + CW'(1);
        end
      end
      OP_POP: begin
        if (nonempty) begin
          count_d = count_q - CW'(1);
          rval    = rdata_q;
          wr_en   = 1'b1;
          wr_addr = AW'(count_q - CW'(1));
        end
      end
      OP_GET: begin
        if (in_range) rval = rdata_q;
      end
      OP_SET: begin
        if (in_range) begin
          wr_en   = 1'b1;
          wr_data = val_q;
          rval    = val_q;
        end
      end
      OP_GET_LAST: begin
        if (nonempty) rval = rdata_q;
      end
      OP_DELETE: begin
        if (in_range) begin
          wr_en  = 1'b1;
          hole_d = idx_q;
        end
      end
      default: ;
    endcase
    wr_en = wr_en && cmd_i.commit;
  end

  assign rval_wide   = 64'(rval);
  assign value_out_d = rval_wide[31:0];

  // count, hole, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hole_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        hole_q      <= hole_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      value_out_q <= value_out_d;
      pidx_q      <= pidx_d;
      fill_q      <= 9'(count_d);
      refused_q   <= refused_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_out_o    = value_out_q;
  assign pushed_index_o = pidx_q;
  assign fill_count_o   = fill_q;
  assign push_refused_o = refused_q;

  // checks
  `STHR_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY))
  `STHR_ASSERT_IMP(a_commit_free, clk_i, rst_ni, cmd_i.commit,
                   !out_valid_q || out_ready_i)
  `STHR_ASSERT_IMP(a_fill_tracks, clk_i, rst_ni, out_valid_q, fill_q == 9'(count_q))
  `STHR_ASSERT_IMP(a_refused_full, clk_i, rst_ni, out_valid_q && refused_q,
                   count_q == CW'(CAPACITY))
  `STHR_ASSERT_NXT(a_load_then_exec, clk_i, rst_ni, cmd_i.load, !cmd_i.load)

endmodule
`default_nettype wire
